>>> rtl/core/tpc_pkg.sv
// Shared types and operation codes for the tree to Prufer code encoder.
`timescale 1ns / 1ps

package tpc_pkg;

  // Width of a vertex label and of a degree count.
  localparam int unsigned LABEL_W = 10;

  // Operation codes carried in the request.
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_NEXT  = 2'd2;

  // Saturation limit of a degree.
  localparam logic [LABEL_W-1:0] DEG_MAX = 10'd1023;

  // Input request.
  typedef struct packed {
    logic [1:0]         op;
    logic [LABEL_W-1:0] end_a;
    logic [LABEL_W-1:0] end_b;
  } tpc_req_t;

  // Result item.
  typedef struct packed {
    logic [LABEL_W-1:0] code_vertex;
    logic               last_code;
    logic               none_left;
  } tpc_rsp_t;

  // One vertex entry: its degree and the XOR of its neighbours' labels.
  typedef struct packed {
    logic [LABEL_W-1:0] deg;
    logic [LABEL_W-1:0] nx;
  } tpc_ent_t;

endpackage

>>> rtl/core/tree_to_prufer_code.sv
// Tree to Prufer code encoder: vertex table memory and its sequencer.
`timescale 1ns / 1ps
//
// Usage. After a clear request, a tree is loaded one edge per add-edge
// request. Each next-code request then removes the smallest leaf other than
// vertex 0 and returns its neighbor as one Prufer entry. Requests enter on
// in_valid/in_stall. Each next-code request yields exactly one result on
// out_valid/out_stall; clear and add-edge requests yield none.
// Timing. All vertex state sits in one memory with one write port and one
// registered read port, so one request is handled at a time. An add-edge
// request holds in_stall high after acceptance for two read-modify-write
// passes (S_ADD_WA, S_ADD_RB, S_ADD_WB). A next-code request checks a held
// leaf (S_HELD_CK), falling back to the scan if it is stale, or scans the
// table entry by entry (S_SCAN_RD, S_SCAN_CK). S_REM_W then registers the
// result, and S_REM_RN and S_REM_WN update the neighbor before the next
// request is taken. The scan visits each entry once per tree. With no code
// left the result is registered straight from the idle state.
// Reset and clear. Reset and each clear request start a clearing pass that
// writes every table entry to zero, one entry a cycle (at most 1024
// entries); in_stall is high meanwhile.
// Stall. A held result stays on out_rsp while out_stall is high, and no new
// request is taken while a result waits under stall.
module tree_to_prufer_code
  import tpc_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 1024
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  tpc_req_t in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output tpc_rsp_t out_rsp
);

  // Labels are 10 bits wide, so no entry above 1023 is ever addressed.
  localparam int unsigned DEPTH    = (MAX_VERTICES < 1024) ? MAX_VERTICES : 1024;
  localparam int unsigned AW       = $clog2(DEPTH);
  localparam int unsigned PW       = AW + 1;
  localparam int unsigned EDGE_CAP = DEPTH - 1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_WA,
    S_ADD_RB,
    S_ADD_WB,
    S_HELD_CK,
    S_SCAN_RD,
    S_SCAN_CK,
    S_REM_W,
    S_REM_RN,
    S_REM_WN
  } state_t;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic [LABEL_W-1:0] edge_total_r, edge_total_nxt;
  logic [LABEL_W-1:0] codes_r, codes_nxt;
  logic [PW-1:0]      scan_ptr_r, scan_ptr_nxt;
  logic [LABEL_W-1:0] cur_leaf_r, cur_leaf_nxt;
  logic [LABEL_W-1:0] ea_r, ea_nxt;
  logic [LABEL_W-1:0] eb_r, eb_nxt;
  logic [LABEL_W-1:0] leaf_r, leaf_nxt;
  logic [LABEL_W-1:0] nb_r, nb_nxt;
  logic               out_valid_r, out_valid_nxt;
  tpc_rsp_t           out_rsp_r, out_rsp_nxt;

  // Vertex table.
  tpc_ent_t           mem [DEPTH];
  tpc_ent_t           mem_rdata_r;
  logic               mem_we;
  logic               mem_re;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      mem_raddr;
  tpc_ent_t           mem_wdata;

  logic               accept;
  logic [PW-1:0]      ptr_inc;
  logic [LABEL_W-1:0] deg_inc;
  logic [LABEL_W-1:0] deg_dec;
  logic [LABEL_W-1:0] nb_ext;

  assign in_stall  = (state_r != S_IDLE) | (out_valid_r & out_stall);
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  assign ptr_inc = scan_ptr_r + PW'(1);
  assign deg_inc = (mem_rdata_r.deg < DEG_MAX) ? mem_rdata_r.deg + 10'd1 : mem_rdata_r.deg;
  assign deg_dec = (mem_rdata_r.deg != 10'd0) ? mem_rdata_r.deg - 10'd1 : 10'd0;
  assign nb_ext  = nb_r;

  // Memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  // Sequencer: next state, memory accesses and result.
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    edge_total_nxt = edge_total_r;
    codes_nxt      = codes_r;
    scan_ptr_nxt   = scan_ptr_r;
    cur_leaf_nxt   = cur_leaf_r;
    ea_nxt         = ea_r;
    eb_nxt         = eb_r;
    leaf_nxt       = leaf_r;
    nb_nxt         = nb_r;
    out_rsp_nxt    = out_rsp_r;
    out_valid_nxt  = out_valid_r & out_stall;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = clr_r;
    mem_raddr      = clr_r;
    mem_wdata      = '0;

    case (state_r)
      S_CLEAR: begin
        // Zero one entry a cycle.
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        clr_nxt   = clr_r + AW'(1);
        if (32'(clr_r) == DEPTH - 1) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          case (in_req.op)
            OP_CLEAR: begin
              clr_nxt        = '0;
              edge_total_nxt = '0;
              codes_nxt      = '0;
              scan_ptr_nxt   = PW'(1);
              cur_leaf_nxt   = '0;
              state_nxt      = S_CLEAR;
            end
            OP_ADD: begin
              // Edges past capacity or with a label out of range are dropped.
              ea_nxt = in_req.end_a;
              eb_nxt = in_req.end_b;
              if ((32'(edge_total_r) < EDGE_CAP) && (32'(in_req.end_a) < MAX_VERTICES) &&
                  (32'(in_req.end_b) < MAX_VERTICES)) begin
                mem_re    = 1'b1;
                mem_raddr = in_req.end_a[AW-1:0];
                state_nxt = S_ADD_WA;
              end
            end
            OP_NEXT: begin
              if ((edge_total_r < 10'd2) || (codes_r >= edge_total_r - 10'd1)) begin
                out_valid_nxt = 1'b1;
                out_rsp_nxt   = '{code_vertex: '0, last_code: 1'b0, none_left: 1'b1};
              end else if (cur_leaf_r != 10'd0) begin
                mem_re    = 1'b1;
                mem_raddr = cur_leaf_r[AW-1:0];
                state_nxt = S_HELD_CK;
              end else begin
                state_nxt = S_SCAN_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_ADD_WA: begin
        mem_we    = 1'b1;
        mem_waddr = ea_r[AW-1:0];
        mem_wdata = '{deg: deg_inc, nx: mem_rdata_r.nx ^ eb_r};
        state_nxt = S_ADD_RB;
      end

      S_ADD_RB: begin
        // Read after the first write lands, so a self loop sees it.
        mem_re    = 1'b1;
        mem_raddr = eb_r[AW-1:0];
        state_nxt = S_ADD_WB;
      end

      S_ADD_WB: begin
        mem_we         = 1'b1;
        mem_waddr      = eb_r[AW-1:0];
        mem_wdata      = '{deg: deg_inc, nx: mem_rdata_r.nx ^ ea_r};
        edge_total_nxt = edge_total_r + 10'd1;
        state_nxt      = S_IDLE;
      end

      S_HELD_CK: begin
        // A held leaf is used only while its degree is still one.
        if (mem_rdata_r.deg == 10'd1) begin
          leaf_nxt  = cur_leaf_r;
          nb_nxt    = mem_rdata_r.nx;
          state_nxt = S_REM_W;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end

      S_SCAN_RD: begin
        if (32'(scan_ptr_r) < DEPTH) begin
          mem_re    = 1'b1;
          mem_raddr = scan_ptr_r[AW-1:0];
          state_nxt = S_SCAN_CK;
        end else begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = '{code_vertex: '0, last_code: 1'b0, none_left: 1'b1};
          state_nxt     = S_IDLE;
        end
      end

      S_SCAN_CK: begin
        // Check one entry and read the next one in the same cycle.
        if (mem_rdata_r.deg == 10'd1) begin
          leaf_nxt  = LABEL_W'(scan_ptr_r[AW-1:0]);
          nb_nxt    = mem_rdata_r.nx;
          state_nxt = S_REM_W;
        end else begin
          scan_ptr_nxt = ptr_inc;
          if (32'(ptr_inc) < DEPTH) begin
            mem_re    = 1'b1;
            mem_raddr = ptr_inc[AW-1:0];
          end else begin
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = '{code_vertex: '0, last_code: 1'b0, none_left: 1'b1};
            state_nxt     = S_IDLE;
          end
        end
      end

      S_REM_W: begin
        // Remove the leaf and report its neighbor.
        mem_we        = 1'b1;
        mem_waddr     = leaf_r[AW-1:0];
        mem_wdata     = '0;
        codes_nxt     = codes_r + 10'd1;
        cur_leaf_nxt  = '0;
        out_valid_nxt = 1'b1;
        out_rsp_nxt   = '{code_vertex: nb_r,
                          last_code: (codes_r + 10'd1) == (edge_total_r - 10'd1),
                          none_left: 1'b0};
        if (32'(nb_ext) < MAX_VERTICES) begin
          state_nxt = S_REM_RN;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_REM_RN: begin
        mem_re    = 1'b1;
        mem_raddr = nb_r[AW-1:0];
        state_nxt = S_REM_WN;
      end

      S_REM_WN: begin
        // Drop the edge at the neighbor; hold it if it became a leaf below the scan.
        mem_we    = 1'b1;
        mem_waddr = nb_r[AW-1:0];
        mem_wdata = '{deg: deg_dec, nx: mem_rdata_r.nx ^ leaf_r};
        if ((nb_r != 10'd0) && (deg_dec == 10'd1) && (32'(nb_r) < 32'(scan_ptr_r))) begin
          cur_leaf_nxt = nb_r;
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      edge_total_r <= '0;
      codes_r      <= '0;
      scan_ptr_r   <= PW'(1);
      cur_leaf_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      edge_total_r <= edge_total_nxt;
      codes_r      <= codes_nxt;
      scan_ptr_r   <= scan_ptr_nxt;
      cur_leaf_r   <= cur_leaf_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    ea_r      <= ea_nxt;
    eb_r      <= eb_nxt;
    leaf_r    <= leaf_nxt;
    nb_r      <= nb_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  // A synchronous reset always starts the clearing pass.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> state_r == S_CLEAR)
    else $error("reset did not start the clearing pass");

  // A waiting result under stall blocks new requests.
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> in_stall)
    else $error("request taken while a result is stalled");

  // A read never targets the entry being written in the same cycle.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write of the same entry in one cycle");

  // No more codes are emitted than edges loaded.
  a_codes_bound: assert property (@(posedge clk) disable iff (!rst_n)
    codes_r <= edge_total_r)
    else $error("code count passed edge count");

  // An empty result carries vertex zero and is never the last code.
  a_none_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rsp_r.none_left) |->
      (out_rsp_r.code_vertex == 10'd0 && !out_rsp_r.last_code))
    else $error("empty result with nonzero fields");

endmodule

>>> verif/tree_to_prufer_code_chk.sv
// Prufer code predictor and result checker for the tree to Prufer code encoder.
`timescale 1ns / 1ps

module tree_to_prufer_code_chk
  import tpc_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  tpc_req_t    in_req,
  input  logic        out_valid,
  input  logic        out_stall,
  input  tpc_rsp_t    out_rsp,
  output int unsigned fail_count,
  output int unsigned pending_codes
);

  localparam int unsigned EDGE_CAP = (MAX_VERTICES - 1 < 1023) ? MAX_VERTICES - 1 : 1023;

  // Mirror of the vertex tables and the leaf scan state.
  logic [LABEL_W-1:0] deg_tab [MAX_VERTICES];
  logic [LABEL_W-1:0] nbr_xor [MAX_VERTICES];
  int unsigned edge_cnt;
  int unsigned codes_out;
  int unsigned scan_ptr;
  int unsigned held_leaf;

  // Codes predicted for accepted next-code requests, oldest first.
  tpc_rsp_t codes_due [$];
  int unsigned errs;

  function automatic void wipe_tree();
    for (int unsigned v = 0; v < MAX_VERTICES; v++) begin
      deg_tab[v] = '0;
      nbr_xor[v] = '0;
    end
    edge_cnt  = 0;
    codes_out = 0;
    scan_ptr  = 1;
    held_leaf = 0;
  endfunction

  function automatic void join_vertices(input logic [LABEL_W-1:0] a,
                                        input logic [LABEL_W-1:0] b);
    if (edge_cnt >= EDGE_CAP) return;
    if (a >= MAX_VERTICES || b >= MAX_VERTICES) return;
    if (deg_tab[a] < DEG_MAX) deg_tab[a] = deg_tab[a] + 1'b1;
    if (deg_tab[b] < DEG_MAX) deg_tab[b] = deg_tab[b] + 1'b1;
    nbr_xor[a] = nbr_xor[a] ^ b;
    nbr_xor[b] = nbr_xor[b] ^ a;
    edge_cnt++;
  endfunction

  // Removes the smallest leaf other than vertex 0 and returns its neighbor.
  function automatic tpc_rsp_t strip_leaf();
    tpc_rsp_t r;
    int unsigned leaf;
    int unsigned nb;
    r = '0;
    r.none_left = 1'b1;
    if (edge_cnt < 2 || codes_out >= edge_cnt - 1) return r;
    leaf = held_leaf;
    if (leaf == 0 || leaf >= MAX_VERTICES || deg_tab[leaf] != 1) begin
      if (scan_ptr == 0) scan_ptr = 1;
      while (scan_ptr < MAX_VERTICES && deg_tab[scan_ptr] != 1) scan_ptr++;
      if (scan_ptr >= MAX_VERTICES) return r;
      leaf = scan_ptr;
    end
    nb = 32'(nbr_xor[leaf]);
    deg_tab[leaf] = '0;
    nbr_xor[leaf] = '0;
    held_leaf = 0;
    if (nb < MAX_VERTICES) begin
      nbr_xor[nb] = nbr_xor[nb] ^ LABEL_W'(leaf);
      if (deg_tab[nb] > 0) deg_tab[nb] = deg_tab[nb] - 1'b1;
      // A neighbor that turns into a leaf behind the pointer is held for the next request.
      if (nb != 0 && deg_tab[nb] == 1 && nb < scan_ptr) held_leaf = nb;
    end
    codes_out++;
    r.code_vertex = LABEL_W'(nb);
    r.last_code   = (codes_out == edge_cnt - 1);
    r.none_left   = 1'b0;
    return r;
  endfunction

  function automatic void log_fault(input string msg);
    errs++;
    if (errs <= 10) $display("tree_to_prufer_code_chk: %s", msg);
  endfunction

  initial begin
    errs = 0;
    wipe_tree();
  end

  // Track accepted requests and compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    tpc_rsp_t want;
    if (!rst_n) begin
      wipe_tree();
      codes_due.delete();
    end else begin
      if (in_valid && !in_stall) begin
        case (in_req.op)
          OP_CLEAR: wipe_tree();
          OP_ADD:   join_vertices(in_req.end_a, in_req.end_b);
          OP_NEXT:  codes_due.push_back(strip_leaf());
          default:  ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (codes_due.size() == 0) begin
          log_fault($sformatf("result with nothing pending: vertex %0d last %0b none %0b",
                              out_rsp.code_vertex, out_rsp.last_code, out_rsp.none_left));
        end else begin
          want = codes_due.pop_front();
          if (want.code_vertex !== out_rsp.code_vertex || want.last_code !== out_rsp.last_code ||
              want.none_left !== out_rsp.none_left) begin
            log_fault($sformatf({"expected vertex %0d last %0b none %0b, ",
                                 "got vertex %0d last %0b none %0b"},
                                want.code_vertex, want.last_code, want.none_left,
                                out_rsp.code_vertex, out_rsp.last_code, out_rsp.none_left));
          end
        end
      end
    end
    fail_count    <= errs;
    pending_codes <= codes_due.size();
  end

endmodule

>>> verif/tree_to_prufer_code_tb.sv
// Top-level testbench for the tree to Prufer code encoder: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tree_to_prufer_code_tb;
  import tpc_pkg::*;

  localparam int unsigned N_VERT   = 1024;
  localparam logic [1:0]  OP_SPARE = 2'd3;

  typedef enum int unsigned {SHAPE_RANDOM, SHAPE_PATH, SHAPE_STAR, SHAPE_BROOM} tree_shape_e;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  tpc_req_t    in_req;
  logic        out_valid;
  logic        out_stall;
  tpc_rsp_t    out_rsp;
  int unsigned fail_count;
  int unsigned pending_codes;

  // When set, neither side idles.
  bit          steady;
  int unsigned reqs_sent;
  bit                 used_label [N_VERT];
  logic [LABEL_W-1:0] label_of   [N_VERT];

  tree_to_prufer_code #(.MAX_VERTICES(N_VERT)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  tree_to_prufer_code_chk #(.MAX_VERTICES(N_VERT)) code_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req        (in_req),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_rsp       (out_rsp),
    .fail_count    (fail_count),
    .pending_codes (pending_codes)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Safety limit well beyond the slowest legal run.
  initial begin
    #20000000;
    $display("tree_to_prufer_code_tb: done, errors");
    $finish;
  end

  // Result side: hold stall for a random number of cycles before each result.
  initial begin
    int unsigned hold;
    out_stall = 1'b0;
    forever begin
      hold = steady ? 0 : $urandom_range(0, 17);
      if (hold != 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Presents one request after a random gap and holds it until it is taken.
  task automatic issue(input logic [1:0] op, input logic [LABEL_W-1:0] a,
                       input logic [LABEL_W-1:0] b);
    int unsigned gap;
    bit taken;
    gap = steady ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req   = '{op: op, end_a: a, end_b: b};
    in_valid = 1'b1;
    do begin
      @(posedge clk);
      taken = !in_stall;
      @(negedge clk);
    end while (!taken);
    if (op != OP_SPARE) reqs_sent++;
  endtask

  task automatic drain_codes();
    in_valid = 1'b0;
    while (pending_codes != 0) @(negedge clk);
  endtask

  // Clears the block, loads a random tree of n_edges edges and asks for its codes.
  task automatic load_tree(input int unsigned n_edges);
    logic [LABEL_W-1:0] ea [];
    logic [LABEL_W-1:0] eb [];
    logic [LABEL_W-1:0] tmp;
    tree_shape_e shape;
    int unsigned p;
    int unsigned j;
    int unsigned pick;
    bit spread;
    bit mixed;
    shape  = tree_shape_e'($urandom_range(0, 3));
    spread = ($urandom_range(0, 1) == 1) && (n_edges < 512);
    mixed  = ($urandom_range(0, 4) == 0);
    ea = new[n_edges];
    eb = new[n_edges];
    foreach (used_label[k]) used_label[k] = 1'b0;
    // Labels are either 0..N or scattered over the whole label range.
    for (int unsigned i = 0; i <= n_edges; i++) begin
      if (!spread) begin
        label_of[i] = LABEL_W'(i);
      end else if (i == 0 && $urandom_range(0, 3) != 0) begin
        label_of[i] = '0;
      end else begin
        do pick = $urandom_range(0, N_VERT - 1); while (used_label[pick]);
        label_of[i] = LABEL_W'(pick);
      end
      used_label[label_of[i]] = 1'b1;
    end
    for (int unsigned i = 1; i <= n_edges; i++) begin
      case (shape)
        SHAPE_RANDOM: p = $urandom_range(0, i - 1);
        SHAPE_PATH:   p = i - 1;
        SHAPE_STAR:   p = 0;
        default:      p = (i < 4) ? 0 : $urandom_range(i - 3, i - 1);
      endcase
      if ($urandom_range(0, 1) == 1) begin
        ea[i-1] = label_of[i];
        eb[i-1] = label_of[p];
      end else begin
        ea[i-1] = label_of[p];
        eb[i-1] = label_of[i];
      end
    end
    // Shuffle the edge order.
    for (int unsigned i = n_edges - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = ea[i]; ea[i] = ea[j]; ea[j] = tmp;
      tmp = eb[i]; eb[i] = eb[j]; eb[j] = tmp;
    end
    issue(OP_CLEAR, LABEL_W'($urandom), LABEL_W'($urandom));
    for (int unsigned i = 0; i < n_edges; i++) begin
      issue(OP_ADD, ea[i], eb[i]);
      if (mixed && $urandom_range(0, 3) == 0)
        issue(OP_NEXT, LABEL_W'($urandom), LABEL_W'($urandom));
    end
    repeat (n_edges - 1 + $urandom_range(0, 2))
      issue(OP_NEXT, LABEL_W'($urandom), LABEL_W'($urandom));
  endtask

  // Unstructured requests, self loops among them, on top of whatever state is left.
  task automatic noise_burst(input int unsigned len);
    logic [LABEL_W-1:0] a;
    logic [LABEL_W-1:0] b;
    int unsigned roll;
    repeat (len) begin
      a = LABEL_W'($urandom);
      b = ($urandom_range(0, 4) == 0) ? a : LABEL_W'($urandom);
      roll = $urandom_range(0, 19);
      if (roll == 0) issue(OP_CLEAR, a, b);
      else if (roll < 3) issue(OP_SPARE, a, b);
      else if (roll < 8) issue(OP_NEXT, a, b);
      else issue(OP_ADD, a, b);
    end
  endtask

  initial begin
    int unsigned roll;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_req    = '0;
    steady    = 1'b0;
    reqs_sent = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Next code with no tree, unused op, and a single edge.
    issue(OP_NEXT, '0, '0);
    issue(OP_SPARE, '1, '1);
    issue(OP_ADD, 10'd1023, 10'd0);
    issue(OP_NEXT, '1, '1);

    // Small tree with vertex 0 as a leaf and the top label, then one request too many.
    issue(OP_CLEAR, '1, '0);
    issue(OP_ADD, 10'd0, 10'd1);
    issue(OP_ADD, 10'd2, 10'd1);
    issue(OP_ADD, 10'd1, 10'd3);
    issue(OP_ADD, 10'd1023, 10'd3);
    repeat (4) issue(OP_NEXT, '0, '0);

    // Self loop: the tree is malformed, so the scan runs out of leaves.
    issue(OP_CLEAR, '0, '1);
    issue(OP_ADD, 10'd0, 10'd2);
    issue(OP_ADD, 10'd2, 10'd2);
    issue(OP_ADD, 10'd2, 10'd1);
    repeat (3) issue(OP_NEXT, '0, '0);
    drain_codes();

    // Edge capacity and degree saturation: self loops past the limit, then an ignored edge.
    steady = 1'b1;
    issue(OP_CLEAR, '0, '0);
    repeat (1030) issue(OP_ADD, 10'd1023, 10'd1023);
    issue(OP_ADD, 10'd0, 10'd1);
    steady = 1'b0;
    repeat (2) issue(OP_NEXT, '0, '0);
    drain_codes();

    // Random part: mostly well-formed trees, some noise in between.
    while (reqs_sent < 1600) begin
      steady = ($urandom_range(0, 4) == 0);
      roll = $urandom_range(0, 19);
      if (roll < 3) noise_burst($urandom_range(4, 16));
      else if (roll == 3) load_tree($urandom_range(25, 300));
      else load_tree($urandom_range(1, 24));
      if ($urandom_range(0, 9) == 0) drain_codes();
    end
    steady = 1'b0;
    drain_codes();
    repeat (40) @(negedge clk);

    if (fail_count == 0 && pending_codes == 0) begin
      $display("tree_to_prufer_code_tb: done, clean");
    end else begin
      $display("tree_to_prufer_code_tb: done, errors");
    end
    $finish;
  end

endmodule
